// ===== rtl/mtd_pkg.sv =====
// Package for the multi-tap detector: request and response payload types,
// configuration bundle, event and phase codes, and register map constants.
// Depends on nothing; every other file in rtl/ but mtd_radius uses it by scoped names.
package mtd_pkg;

	// Event kinds carried in req_type. Codes above EV_WHEEL act like a wheel event.
	localparam logic [2:0] EV_PRESS   = 3'd0;
	localparam logic [2:0] EV_MOVE    = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_CANCEL  = 3'd3;
	localparam logic [2:0] EV_WHEEL   = 3'd4;

	// Encoded gesture state as it appears on the response.
	localparam logic [1:0] GS_POSSIBLE = 2'd0;
	localparam logic [1:0] GS_ENDED    = 2'd1;
	localparam logic [1:0] GS_FAILED   = 2'd2;

	// Internal gesture phase.
	typedef enum logic [2:0] {
		PH_POSSIBLE = 3'b001,
		PH_ENDED    = 3'b010,
		PH_FAILED   = 3'b100
	} phase_t;

	// Register map: index of each register (byte address is 4 * index).
	localparam int          ADDR_W        = 4;
	localparam logic [1:0]  REG_REQ_TAPS  = 2'd0;
	localparam logic [1:0]  REG_INTERVAL  = 2'd1;
	localparam logic [1:0]  REG_PRESS_MAX = 2'd2;
	localparam logic [1:0]  REG_RADIUS    = 2'd3;

	// Reset values of the registers.
	localparam logic [3:0]  RST_REQ_TAPS  = 4'd1;
	localparam logic [31:0] RST_INTERVAL  = 32'd300000;
	localparam logic [31:0] RST_PRESS_MAX = 32'd500000;
	localparam logic [15:0] RST_RADIUS    = 16'd160;
	localparam logic [31:0] RST_RADIUS_SQ = 32'd25600;

	typedef struct packed {
		logic [2:0]         req_type;
		logic [3:0]         ptr_id;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic [31:0]        time_us;
	} req_t;

	typedef struct packed {
		logic [1:0] gesture_state;
		logic       recognized;
		logic       failed_now;
		logic [3:0] taps_so_far;
	} rsp_t;

	// Configuration as the datapath sees it; the radius arrives already squared.
	typedef struct packed {
		logic [3:0]  required_taps;
		logic [31:0] max_tap_interval;
		logic [31:0] max_press_time;
		logic [31:0] radius_sq;
	} cfg_t;

endpackage

// ===== rtl/mtd_cfg.sv =====
// Configuration register file of the multi-tap detector behind an APB-style port.
// Depends on mtd_pkg for the register map, reset values and the cfg_t bundle.
module mtd_cfg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mtd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	output mtd_pkg::cfg_t              cfg
);

	logic [3:0]  req_taps_q;
	logic [31:0] interval_q;
	logic [31:0] press_max_q;
	logic [15:0] radius_q;
	logic [31:0] radius_sq_q;
	logic [1:0]  index;
	logic        wr_en;

	assign pready = 1'b1;
	assign index  = paddr[mtd_pkg::ADDR_W-1:2];
	assign wr_en  = psel & penable & pwrite;

	// The radius is squared once at write time so the datapath only compares.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_taps_q  <= mtd_pkg::RST_REQ_TAPS;
			interval_q  <= mtd_pkg::RST_INTERVAL;
			press_max_q <= mtd_pkg::RST_PRESS_MAX;
			radius_q    <= mtd_pkg::RST_RADIUS;
			radius_sq_q <= mtd_pkg::RST_RADIUS_SQ;
		end else if (wr_en) begin
			unique case (index)
				mtd_pkg::REG_REQ_TAPS:  req_taps_q  <= pwdata[3:0];
				mtd_pkg::REG_INTERVAL:  interval_q  <= pwdata;
				mtd_pkg::REG_PRESS_MAX: press_max_q <= pwdata;
				mtd_pkg::REG_RADIUS: begin
					radius_q    <= pwdata[15:0];
					radius_sq_q <= {16'd0, pwdata[15:0]} * {16'd0, pwdata[15:0]};
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (index)
			mtd_pkg::REG_REQ_TAPS:  prdata = {28'd0, req_taps_q};
			mtd_pkg::REG_INTERVAL:  prdata = interval_q;
			mtd_pkg::REG_PRESS_MAX: prdata = press_max_q;
			mtd_pkg::REG_RADIUS:    prdata = {16'd0, radius_q};
			default:                prdata = 32'd0;
		endcase
	end

	assign cfg.required_taps    = req_taps_q;
	assign cfg.max_tap_interval = interval_q;
	assign cfg.max_press_time   = press_max_q;
	assign cfg.radius_sq        = radius_sq_q;

endmodule

// ===== rtl/mtd_radius.sv =====
// Squared-distance test of the multi-tap detector: is a point farther than the
// configured radius from the recorded press point. Uses no package items.
module mtd_radius (
	input  logic signed [15:0] pos_x,
	input  logic signed [15:0] pos_y,
	input  logic signed [15:0] press_x,
	input  logic signed [15:0] press_y,
	input  logic [31:0]        radius_sq,
	output logic               beyond
);

	logic signed [16:0] dx;
	logic signed [16:0] dy;
	logic [16:0]        dx_neg;
	logic [16:0]        dy_neg;
	logic [15:0]        adx;
	logic [15:0]        ady;
	logic [31:0]        sq_x;
	logic [31:0]        sq_y;
	logic [32:0]        dist_sq;

	always_comb begin
		dx     = {pos_x[15], pos_x} - {press_x[15], press_x};
		dy     = {pos_y[15], pos_y} - {press_y[15], press_y};
		dx_neg = -dx;
		dy_neg = -dy;
		// The magnitude of a 17-bit difference of two 16-bit values fits in 16 bits.
		adx     = dx[16] ? dx_neg[15:0] : dx[15:0];
		ady     = dy[16] ? dy_neg[15:0] : dy[15:0];
		sq_x    = {16'd0, adx} * {16'd0, adx};
		sq_y    = {16'd0, ady} * {16'd0, ady};
		dist_sq = {1'b0, sq_x} + {1'b0, sq_y};
		beyond  = dist_sq > {1'b0, radius_sq};
	end

endmodule

// ===== rtl/mtd_core.sv =====
// Gesture state and per-request update logic of the multi-tap detector.
// Depends on mtd_pkg and on mtd_radius for the distance test.
module mtd_core (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  mtd_pkg::req_t req,
	input  mtd_pkg::cfg_t cfg,
	output mtd_pkg::rsp_t rsp
);

	mtd_pkg::phase_t    phase_q, phase_n;
	logic               pressed_q, pressed_n;
	logic [3:0]         count_q, count_n;
	logic [3:0]         tracked_q, tracked_n;
	logic signed [15:0] press_x_q, press_x_n;
	logic signed [15:0] press_y_q, press_y_n;
	logic [31:0]        press_t_q, press_t_n;
	logic [31:0]        rel_t_q, rel_t_n;
	logic               rel_seen_q, rel_seen_n;

	logic        beyond;
	logic        recog;
	logic        failed;
	logic [3:0]  need;
	logic [31:0] gap;
	logic [31:0] held;
	logic [3:0]  count_inc;
	logic        own;
	logic        term;

	mtd_radius u_radius (
		.pos_x     (req.pos_x),
		.pos_y     (req.pos_y),
		.press_x   (press_x_q),
		.press_y   (press_y_q),
		.radius_sq (cfg.radius_sq),
		.beyond    (beyond)
	);

	always_comb begin
		// An ended or failed gesture starts over before the request is handled.
		term       = phase_q != mtd_pkg::PH_POSSIBLE;
		phase_n    = mtd_pkg::PH_POSSIBLE;
		pressed_n  = term ? 1'b0 : pressed_q;
		count_n    = term ? 4'd0 : count_q;
		rel_seen_n = term ? 1'b0 : rel_seen_q;
		tracked_n  = tracked_q;
		press_x_n  = press_x_q;
		press_y_n  = press_y_q;
		press_t_n  = press_t_q;
		rel_t_n    = rel_t_q;
		recog      = 1'b0;
		failed     = 1'b0;

		need      = (cfg.required_taps == 4'd0) ? 4'd1 : cfg.required_taps;
		gap       = req.time_us - rel_t_q;
		held      = req.time_us - press_t_q;
		own       = req.ptr_id == tracked_q;
		count_inc = (count_n == 4'd15) ? count_n : count_n + 4'd1;

		case (req.req_type)
			mtd_pkg::EV_CANCEL: begin
				phase_n = mtd_pkg::PH_FAILED;
				failed  = 1'b1;
			end
			mtd_pkg::EV_PRESS: begin
				if (!pressed_n) begin
					if (rel_seen_n && (gap > cfg.max_tap_interval)) begin
						count_n = 4'd0;
					end
					tracked_n = req.ptr_id;
					pressed_n = 1'b1;
					press_x_n = req.pos_x;
					press_y_n = req.pos_y;
					press_t_n = req.time_us;
				end else if (own && beyond) begin
					// A second press by the tracked pointer is treated as a move.
					phase_n = mtd_pkg::PH_FAILED;
					failed  = 1'b1;
				end
			end
			mtd_pkg::EV_MOVE: begin
				if (pressed_n && own && beyond) begin
					phase_n = mtd_pkg::PH_FAILED;
					failed  = 1'b1;
				end
			end
			mtd_pkg::EV_RELEASE: begin
				if (pressed_n && own) begin
					pressed_n = 1'b0;
					if ((held > cfg.max_press_time) || beyond) begin
						phase_n = mtd_pkg::PH_FAILED;
						failed  = 1'b1;
					end else begin
						count_n    = count_inc;
						rel_t_n    = req.time_us;
						rel_seen_n = 1'b1;
						if (count_inc >= need) begin
							phase_n = mtd_pkg::PH_ENDED;
							recog   = 1'b1;
						end
					end
				end
			end
			default: ;
		endcase

		case (phase_n)
			mtd_pkg::PH_ENDED:  rsp.gesture_state = mtd_pkg::GS_ENDED;
			mtd_pkg::PH_FAILED: rsp.gesture_state = mtd_pkg::GS_FAILED;
			default:            rsp.gesture_state = mtd_pkg::GS_POSSIBLE;
		endcase
		rsp.recognized  = recog;
		rsp.failed_now  = failed;
		rsp.taps_so_far = count_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= mtd_pkg::PH_POSSIBLE;
			pressed_q  <= 1'b0;
			count_q    <= 4'd0;
			tracked_q  <= 4'd0;
			press_x_q  <= 16'sd0;
			press_y_q  <= 16'sd0;
			press_t_q  <= 32'd0;
			rel_t_q    <= 32'd0;
			rel_seen_q <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_n;
			pressed_q  <= pressed_n;
			count_q    <= count_n;
			tracked_q  <= tracked_n;
			press_x_q  <= press_x_n;
			press_y_q  <= press_y_n;
			press_t_q  <= press_t_n;
			rel_t_q    <= rel_t_n;
			rel_seen_q <= rel_seen_n;
		end
	end

endmodule

// ===== rtl/multi_tap_detector.sv =====
// Top level of the multi-tap detector: request register, gesture core and
// response register. Depends on mtd_pkg, mtd_cfg, mtd_core and mtd_radius.
//
// Usage. Pointer events enter as requests on req (kind, pointer id, position
// in sixteenths of a pixel, microsecond timestamp) under req_valid/req_stall.
// Each request yields exactly one response on rsp under rsp_valid/rsp_stall:
// the gesture state after the event, a recognized flag, a failed-now flag and
// the tap count. A transfer happens at a clock edge where valid is high and
// stall is low.
// The request is captured in an input register, the core evaluates it
// combinationally and the response register presents the result.
// Throughput is one request per cycle while the receiver does not stall, set
// by the core's single state-update pass (two 16x16 squares, add, compare).
// If the receiver stalls, the response register holds its item, the request
// register keeps the one behind it, and req_stall rises only when both are
// full. Reset (arst_n low) clears the gesture to possible with no taps, no
// press and no release recorded, and restores the register defaults:
// one tap, 300000 us interval, 500000 us press time, radius 160.
// The user must write registers over the APB-style port only while the block is idle; the block does not enforce this.
module multi_tap_detector (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  mtd_pkg::req_t              req,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output mtd_pkg::rsp_t              rsp,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [mtd_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready
);

	mtd_pkg::cfg_t cfg;
	mtd_pkg::req_t req_s1;
	mtd_pkg::rsp_t rsp_next;
	mtd_pkg::rsp_t rsp_s2;
	logic          valid_s1;
	logic          valid_s2;
	logic          advance;
	logic          take;

	mtd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// The request in stage one moves on whenever the response slot is free
	// or is being emptied in this cycle.
	assign advance   = valid_s1 & (~valid_s2 | ~rsp_stall);
	assign req_stall = valid_s1 & ~advance;
	assign take      = req_valid & ~req_stall;

	mtd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.rsp    (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (~rsp_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= rsp_next;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule
